// ----- hw/rtl/array_linked_list_manager_defines.svh -----
// Assertion macros shared by the linked list manager RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ARRAY_LINKED_LIST_MANAGER_DEFINES_SVH
`define ARRAY_LINKED_LIST_MANAGER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define ALLM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define ALLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/allm_pkg.sv -----
// Shared constants and types of the linked list manager.
// No dependencies; used by the top level array_linked_list_manager.
`default_nettype none

package allm_pkg;

   // default node store depth
   localparam int NODES_DEFAULT = 16;

   // payload widths
   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 3;

   // request modes
   localparam logic [MODE_W-1:0] MODE_FRONT  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_END    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BEFORE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_AT     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOKEY  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NEGPOS = 3'd4;
   localparam logic [STATUS_W-1:0] ST_PAST   = 3'd5;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_TAKE,
      S_READ,
      S_END,
      S_KEY,
      S_POS,
      S_FIX
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/allm_ram.sv -----
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module allm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/allm_link_store.sv -----
// Link store: link RAM plus per-entry valid bits so that an unwritten entry i
// reads as link i+1. Depends on allm_ram.
`default_nettype none

module allm_link_store #(
   parameter int NODES = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(NODES)-1:0]   wr_addr,
   input  wire logic [$clog2(NODES+1)-1:0] wr_data,
   input  wire logic [$clog2(NODES)-1:0]   rd_addr,
   output      logic [$clog2(NODES+1)-1:0] rd_data
);

   localparam int AW = $clog2(NODES);
   localparam int LW = $clog2(NODES + 1);

   logic [NODES-1:0] valid_ff;
   logic             rd_valid_ff;
   logic [AW-1:0]    rd_addr_ff;
   logic [LW-1:0]    ram_data;

   allm_ram #(
      .WIDTH (LW),
      .DEPTH (NODES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   // mark entries as written
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // track validity and address alongside the RAM read
   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_addr];
      rd_addr_ff  <= rd_addr;
   end

   // substitute the reset link for entries never written
   assign rd_data = rd_valid_ff ? ram_data : (LW'(rd_addr_ff) + LW'(1));

endmodule

`default_nettype wire

// ----- hw/rtl/array_linked_list_manager.sv -----
// Top level of the linked list manager: request sequencer and node stores.
// Depends on allm_pkg, allm_ram, allm_link_store and the assertion macros.
`default_nettype none
`include "array_linked_list_manager_defines.svh"

// A request is taken when start is high and busy is low; busy stays high until
// the request is finished. Immediate answers (list empty, negative position, no
// free node) come from the decision state, modes five to seven are ignored with
// no result, a front insert ends once its node is taken, and requests that walk
// the list follow one link per cycle through the link RAM read port. Each result
// is shown, registered, on the rsp_ ports for exactly one cycle with rsp_strobe
// high, and the receiver cannot stall it: a read-out delivers one element per
// cycle back to back, rsp_last marking the final one. Insert requests give
// exactly one status result. No clearing pass runs after reset; the block
// accepts requests from the first cycle.
module array_linked_list_manager #(
   parameter int NODES = allm_pkg::NODES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic [allm_pkg::MODE_W-1:0]         req_mode,
   input  wire logic signed [allm_pkg::VALUE_W-1:0] req_value,
   input  wire logic signed [allm_pkg::VALUE_W-1:0] req_key,
   input  wire logic signed [allm_pkg::POS_W-1:0]   req_position,
   output      logic                                rsp_strobe,
   output      logic [allm_pkg::STATUS_W-1:0]       rsp_status,
   output      logic signed [allm_pkg::VALUE_W-1:0] rsp_data,
   output      logic                                rsp_last
);

   localparam int AW  = $clog2(NODES);
   localparam int LW  = $clog2(NODES + 1);
   localparam int VW  = allm_pkg::VALUE_W;
   localparam int PW  = allm_pkg::POS_W;
   localparam logic [LW-1:0] NIL_LINK = LW'(NODES);

   // control state
   allm_pkg::state_type state_ff, state_in;
   logic [LW-1:0]       list_head_ff, list_head_in;
   logic [LW-1:0]       free_head_ff, free_head_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   // request and walk registers
   logic [allm_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [VW-1:0]                 value_ff, value_in;
   logic [VW-1:0]                 key_ff, key_in;
   logic [PW-1:0]                 pos_ff, pos_in;
   logic [AW-1:0]                 nn_ff, nn_in;
   logic [LW-1:0]                 nfree_ff, nfree_in;
   logic [AW-1:0]                 cur_ff, cur_in;
   logic [AW-1:0]                 prev_ff, prev_in;
   logic                          first_ff, first_in;
   logic [PW-2:0]                 steps_ff, steps_in;
   logic [allm_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VW-1:0]                 rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;

   // memory ports
   logic [AW-1:0] rd_addr;
   logic          link_we;
   logic [AW-1:0] link_waddr;
   logic [LW-1:0] link_wdata;
   logic [LW-1:0] link_rdata;
   logic          value_we;
   logic [VW-1:0] value_rdata;

   // walk helpers
   logic          head_nil;
   logic          link_nil;
   logic [AW-1:0] link_next;
   logic [PW-1:0] steps_next;

   allm_link_store #(
      .NODES (NODES)
   ) u_link_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (rd_addr),
      .rd_data (link_rdata)
   );

   allm_ram #(
      .WIDTH (VW),
      .DEPTH (NODES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (value_we),
      .wr_addr (nn_ff),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (value_rdata)
   );

   assign head_nil   = (list_head_ff == NIL_LINK);
   assign link_nil   = (link_rdata == NIL_LINK);
   assign link_next  = link_rdata[AW-1:0];
   assign steps_next = {1'b0, steps_ff} + PW'(1);

   // next state, memory accesses and results
   always_comb begin
      state_in      = state_ff;
      list_head_in  = list_head_ff;
      free_head_in  = free_head_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      nn_in         = nn_ff;
      nfree_in      = nfree_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      first_in      = first_ff;
      steps_in      = steps_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = allm_pkg::ST_OK;
      rsp_data_in   = '0;
      rsp_last_in   = 1'b1;
      rd_addr       = '0;
      link_we       = 1'b0;
      link_waddr    = nn_ff;
      link_wdata    = NIL_LINK;
      value_we      = 1'b0;

      unique case (state_ff)
         allm_pkg::S_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               value_in = req_value;
               key_in   = req_key;
               pos_in   = req_position;
               state_in = allm_pkg::S_DECIDE;
            end
         end

         // answer the immediate cases, else start a read-out or take a node
         allm_pkg::S_DECIDE: begin
            priority if (mode_ff > allm_pkg::MODE_READ) begin
               state_in = allm_pkg::S_IDLE;
            end else if (mode_ff == allm_pkg::MODE_READ) begin
               if (head_nil) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = allm_pkg::ST_EMPTY;
                  state_in      = allm_pkg::S_IDLE;
               end else begin
                  rd_addr  = list_head_ff[AW-1:0];
                  cur_in   = list_head_ff[AW-1:0];
                  state_in = allm_pkg::S_READ;
               end
            end else if (mode_ff == allm_pkg::MODE_BEFORE && head_nil) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = allm_pkg::ST_EMPTY;
               state_in      = allm_pkg::S_IDLE;
            end else if (mode_ff == allm_pkg::MODE_AT && pos_ff[PW-1]) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = allm_pkg::ST_NEGPOS;
               state_in      = allm_pkg::S_IDLE;
            end else if (free_head_ff == NIL_LINK) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = allm_pkg::ST_FULL;
               state_in      = allm_pkg::S_IDLE;
            end else begin
               rd_addr  = free_head_ff[AW-1:0];
               nn_in    = free_head_ff[AW-1:0];
               state_in = allm_pkg::S_TAKE;
            end
         end

         // link of the new node arrives: it becomes the next free head once the node is placed
         allm_pkg::S_TAKE: begin
            nfree_in = link_rdata;
            priority if (mode_ff == allm_pkg::MODE_FRONT ||
                         (mode_ff == allm_pkg::MODE_AT && pos_ff == '0)) begin
               link_we       = 1'b1;
               link_wdata    = list_head_ff;
               value_we      = 1'b1;
               list_head_in  = LW'(nn_ff);
               free_head_in  = link_rdata;
               rsp_strobe_in = 1'b1;
               state_in      = allm_pkg::S_IDLE;
            end else if (mode_ff == allm_pkg::MODE_END) begin
               link_we      = 1'b1;
               link_wdata   = NIL_LINK;
               value_we     = 1'b1;
               free_head_in = link_rdata;
               if (head_nil) begin
                  list_head_in  = LW'(nn_ff);
                  rsp_strobe_in = 1'b1;
                  state_in      = allm_pkg::S_IDLE;
               end else begin
                  rd_addr  = list_head_ff[AW-1:0];
                  cur_in   = list_head_ff[AW-1:0];
                  state_in = allm_pkg::S_END;
               end
            end else if (mode_ff == allm_pkg::MODE_BEFORE) begin
               rd_addr  = list_head_ff[AW-1:0];
               cur_in   = list_head_ff[AW-1:0];
               first_in = 1'b1;
               state_in = allm_pkg::S_KEY;
            end else begin
               if (head_nil) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = allm_pkg::ST_PAST;
                  state_in      = allm_pkg::S_IDLE;
               end else begin
                  rd_addr  = list_head_ff[AW-1:0];
                  cur_in   = list_head_ff[AW-1:0];
                  steps_in = '0;
                  state_in = allm_pkg::S_POS;
               end
            end
         end

         // emit one element per cycle while chasing links
         allm_pkg::S_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = value_rdata;
            rsp_last_in   = link_nil;
            if (link_nil) begin
               state_in = allm_pkg::S_IDLE;
            end else begin
               rd_addr = link_next;
               cur_in  = link_next;
            end
         end

         // find the tail and hook the new node behind it
         allm_pkg::S_END: begin
            if (link_nil) begin
               link_we       = 1'b1;
               link_waddr    = cur_ff;
               link_wdata    = LW'(nn_ff);
               rsp_strobe_in = 1'b1;
               state_in      = allm_pkg::S_IDLE;
            end else begin
               rd_addr = link_next;
               cur_in  = link_next;
            end
         end

         // search for the key; a miss leaves the free list untouched
         allm_pkg::S_KEY: begin
            if (value_rdata == key_ff) begin
               link_we      = 1'b1;
               link_wdata   = LW'(cur_ff);
               value_we     = 1'b1;
               free_head_in = nfree_ff;
               if (first_ff) begin
                  list_head_in  = LW'(nn_ff);
                  rsp_strobe_in = 1'b1;
                  state_in      = allm_pkg::S_IDLE;
               end else begin
                  state_in = allm_pkg::S_FIX;
               end
            end else if (link_nil) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = allm_pkg::ST_NOKEY;
               state_in      = allm_pkg::S_IDLE;
            end else begin
               prev_in  = cur_ff;
               cur_in   = link_next;
               rd_addr  = link_next;
               first_in = 1'b0;
            end
         end

         // advance to the node before the position, then splice after it
         allm_pkg::S_POS: begin
            if (steps_next < pos_ff) begin
               if (link_nil) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = allm_pkg::ST_PAST;
                  state_in      = allm_pkg::S_IDLE;
               end else begin
                  cur_in   = link_next;
                  rd_addr  = link_next;
                  steps_in = steps_next[PW-2:0];
               end
            end else begin
               link_we      = 1'b1;
               link_wdata   = link_rdata;
               value_we     = 1'b1;
               free_head_in = nfree_ff;
               prev_in      = cur_ff;
               state_in     = allm_pkg::S_FIX;
            end
         end

         // point the predecessor at the new node
         allm_pkg::S_FIX: begin
            link_we       = 1'b1;
            link_waddr    = prev_ff;
            link_wdata    = LW'(nn_ff);
            rsp_strobe_in = 1'b1;
            state_in      = allm_pkg::S_IDLE;
         end

         default: begin
            state_in = allm_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= allm_pkg::S_IDLE;
         list_head_ff  <= NIL_LINK;
         free_head_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         list_head_ff  <= list_head_in;
         free_head_ff  <= free_head_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      nn_ff         <= nn_in;
      nfree_ff      <= nfree_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      first_ff      <= first_in;
      steps_ff      <= steps_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy       = (state_ff != allm_pkg::S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_last   = rsp_last_ff;

   // the two lists never share their first node
   `ALLM_ASSERT_NOW(a_heads_apart, clock, reset, list_head_ff != NIL_LINK,
      list_head_ff != free_head_ff, "list and free heads coincide")
   // a non-final result is a read-out element and is followed at once by another
   `ALLM_ASSERT_NEXT(a_readout_gapless, clock, reset, rsp_strobe && !rsp_last,
      rsp_strobe && rsp_status == allm_pkg::ST_OK, "read-out stream broken")
   // an accepted request holds the block busy in the next cycle
   `ALLM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
      "request accepted but block not busy")

endmodule

`default_nettype wire
